FILE: sv/qdd_pkg.sv
// Shared types, constants and helpers for the quadrature detent decoder.
package qdd_pkg;

   localparam int unsigned NUM_ENCODERS = 4;

   localparam int unsigned ENC_W      = 2;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned DELTA_W    = 4;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned TH_W       = 4;
   localparam int unsigned VH_W       = 8;
   localparam int unsigned ACCEL_W    = 4;
   localparam int unsigned GAIN_W     = 3;

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_MASK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT     = 1'b1;

   localparam logic [VH_W-1:0] PAT_UP   = 8'hd4;
   localparam logic [VH_W-1:0] PAT_DOWN = 8'he8;

   localparam int unsigned ACCEL_WINDOW = 40;
   localparam int unsigned ACCEL_STEP   = 10;
   localparam int unsigned ACCEL_DT_W   = $clog2(ACCEL_WINDOW);

   localparam logic QUAD_OK [16] = '{
      1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
      1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0
   };

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              cmd;
      logic [ENC_W-1:0]  encoder_index;
      logic              pin_a_level;
      logic              pin_b_level;
      logic [TIME_W-1:0] time_ms;
   } req_item_type;

   typedef struct packed {
      logic [ENC_W-1:0]          encoder_id;
      logic                      detent_seen;
      logic signed [DELTA_W-1:0] step_delta;
      logic signed [COUNT_W-1:0] count_value;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_READ,
      OP_SKIP
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [ENC_W-1:0]  enc_id;
      logic [1:0]        ab_code;
      logic [TIME_W-1:0] time_ms;
   } op_type;

   // gain = (WINDOW - dt) / STEP + 1, valid for dt < WINDOW
   function automatic logic [GAIN_W-1:0] accel_gain(input logic [ACCEL_DT_W-1:0] dt);
      logic [GAIN_W-1:0] g;
      g = GAIN_W'(1);
      for (int k = 1; k <= int'(ACCEL_WINDOW / ACCEL_STEP); k++) begin
         if (int'(dt) <= int'(ACCEL_WINDOW) - int'(ACCEL_STEP) * k) begin
            g = g + GAIN_W'(1);
         end
      end
      return g;
   endfunction

endpackage

FILE: sv/qdd_front.sv
// Front stage: accepts request items and classifies them into operations.
module qdd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qdd_pkg::req_item_type req_item,
   output logic                 push_valid,
   input  logic                 push_ready,
   output qdd_pkg::op_type      push_op
);
   import qdd_pkg::*;

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   logic   accept;

   assign req_ready  = !valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_op    = op_ff;

   always_comb begin
      valid_in = valid_ff;
      op_in    = op_ff;
      if (push_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in      = 1'b1;
         op_in.enc_id  = req_item.encoder_index;
         op_in.ab_code = {!req_item.pin_a_level, !req_item.pin_b_level};
         op_in.time_ms = req_item.time_ms;
         if (int'(req_item.encoder_index) >= int'(NUM_ENCODERS)) begin
            op_in.kind = OP_SKIP;
         end else if (req_item.cmd) begin
            op_in.kind = OP_READ;
         end else begin
            op_in.kind = OP_SAMPLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      op_ff <= op_in;
   end

endmodule

FILE: sv/qdd_queue.sv
// Small queue of classified operations between front and back.
module qdd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  qdd_pkg::op_type push_op,
   output logic            pop_valid,
   input  logic            pop_ready,
   output qdd_pkg::op_type pop_op
);
   import qdd_pkg::*;

   op_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: sv/qdd_back.sv
// Back stage: per-encoder state, detent decode, acceleration, accumulate, result register.
module qdd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [qdd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qdd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               op_valid,
   output logic                               op_ready,
   input  qdd_pkg::op_type                    op,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output qdd_pkg::rsp_item_type              rsp_item
);
   import qdd_pkg::*;

   logic [TH_W-1:0]           th_ff   [NUM_ENCODERS];
   logic [TH_W-1:0]           th_in   [NUM_ENCODERS];
   logic [VH_W-1:0]           vh_ff   [NUM_ENCODERS];
   logic [VH_W-1:0]           vh_in   [NUM_ENCODERS];
   logic [TIME_W-1:0]         last_ff [NUM_ENCODERS];
   logic [TIME_W-1:0]         last_in [NUM_ENCODERS];
   logic signed [COUNT_W-1:0] acc_ff  [NUM_ENCODERS];
   logic signed [COUNT_W-1:0] acc_in  [NUM_ENCODERS];

   logic [ACCEL_W-1:0] mask_ff, mask_in;
   logic               report_ff, report_in;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_item_ff, out_item_in;

   logic                      take;
   logic [TH_W-1:0]           th_new;
   logic                      ok;
   logic [VH_W-1:0]           vh_new;
   logic                      is_up, is_down, accel;
   logic [TIME_W-1:0]         dt;
   logic [GAIN_W-1:0]         mag;
   logic signed [DELTA_W-1:0] mag_s, delta;
   logic signed [COUNT_W:0]   sum;
   logic signed [COUNT_W-1:0] sat;
   logic [ACCEL_W-1:0]        changed;

   assign op_ready  = !out_valid_ff || rsp_ready;
   assign take      = op_valid && op_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      th_new  = {th_ff[op.enc_id][1:0], op.ab_code};
      ok      = QUAD_OK[th_new];
      vh_new  = ok ? {vh_ff[op.enc_id][TH_W-1:0], th_new} : vh_ff[op.enc_id];
      is_up   = ok && (vh_new == PAT_UP);
      is_down = ok && (vh_new == PAT_DOWN);
      accel   = mask_ff[op.enc_id];
      dt      = op.time_ms - last_ff[op.enc_id];
      mag     = (accel && (dt < TIME_W'(ACCEL_WINDOW)))
                ? accel_gain(dt[ACCEL_DT_W-1:0]) : GAIN_W'(1);
      mag_s   = $signed({1'b0, mag});
      delta   = is_down ? -mag_s : mag_s;
      sum     = (COUNT_W+1)'(acc_ff[op.enc_id]) + (COUNT_W+1)'(delta);
      if (sum > (COUNT_W+1)'(32767)) begin
         sat = 16'sh7fff;
      end else if (sum < -(COUNT_W+1)'(32768)) begin
         sat = 16'sh8000;
      end else begin
         sat = sum[COUNT_W-1:0];
      end
      changed = csr_wdata[ACCEL_W-1:0] ^ mask_ff;
   end

   always_comb begin
      th_in        = th_ff;
      vh_in        = vh_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      mask_in      = mask_ff;
      report_in    = report_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;

      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (take) begin
         out_valid_in            = 1'b1;
         out_item_in             = '0;
         out_item_in.encoder_id  = op.enc_id;
         case (op.kind)
            OP_SAMPLE: begin
               th_in[op.enc_id] = th_new;
               vh_in[op.enc_id] = vh_new;
               if (is_up || is_down) begin
                  out_item_in.detent_seen = 1'b1;
                  out_item_in.step_delta  = delta;
                  out_item_in.count_value = sat;
                  acc_in[op.enc_id]       = report_ff ? '0 : sat;
                  if (accel) begin
                     last_in[op.enc_id] = op.time_ms;
                  end
               end else begin
                  out_item_in.count_value = acc_ff[op.enc_id];
               end
            end
            OP_READ: begin
               out_item_in.count_value = acc_ff[op.enc_id];
               acc_in[op.enc_id]       = '0;
            end
            default: begin
            end
         endcase
      end

      if (csr_we) begin
         case (csr_index)
            CSR_ACCEL_MASK: begin
               mask_in = csr_wdata[ACCEL_W-1:0];
               for (int e = 0; e < int'(NUM_ENCODERS); e++) begin
                  if (e < int'(ACCEL_W) && changed[e % ACCEL_W]) begin
                     th_in[e]   = '0;
                     vh_in[e]   = '0;
                     last_in[e] = '0;
                     acc_in[e]  = '0;
                  end
               end
            end
            CSR_REPORT: begin
               report_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < int'(NUM_ENCODERS); e++) begin
            th_ff[e]   <= '0;
            vh_ff[e]   <= '0;
            last_ff[e] <= '0;
            acc_ff[e]  <= '0;
         end
         mask_ff      <= '0;
         report_ff    <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         th_ff        <= th_in;
         vh_ff        <= vh_in;
         last_ff      <= last_in;
         acc_ff       <= acc_in;
         mask_ff      <= mask_in;
         report_ff    <= report_in;
         out_valid_ff <= out_valid_in;
      end
      out_item_ff <= out_item_in;
   end

endmodule

FILE: sv/quadrature_detent_decoder_accel.sv
// Top level of the quadrature detent decoder with speed acceleration.
//
//   channel   ports                         direction  handshake
//   request   req_valid/req_ready/req_item  in         valid/ready
//   response  rsp_valid/rsp_ready/rsp_item  out        valid/ready
//   config    csr_we/csr_index/csr_wdata    in         write enable, no wait
//
// One item per cycle sustained while rsp_ready stays high; each item produces one
// response, registered in turn by the front register, queue and back result register.
// The back stage updates per-encoder state as it takes each item, so items for the
// same encoder follow back to back. Synchronous reset clears all encoder state,
// the mask (0) and the report flag (1). A stalled response fills the queue, then
// the front register, before req_ready drops.
module quadrature_detent_decoder_accel (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  qdd_pkg::req_item_type          req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output qdd_pkg::rsp_item_type          rsp_item,
   input  logic                           csr_we,
   input  logic [qdd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qdd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import qdd_pkg::*;

   logic   push_valid, push_ready;
   op_type push_op;
   logic   pop_valid, pop_ready;
   op_type pop_op;

   qdd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   qdd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   qdd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .op_valid  (pop_valid),
      .op_ready  (pop_ready),
      .op        (pop_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   a_detent_has_delta: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.detent_seen |-> rsp_item.step_delta != '0)
      else $error("detent reported with zero delta");

   a_no_detent_zero_delta: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.detent_seen |-> rsp_item.step_delta == '0)
      else $error("nonzero delta without detent");

   a_delta_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.step_delta >= -4'sd5) && (rsp_item.step_delta <= 4'sd5))
      else $error("step delta out of range");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

FILE: dv/tb_quadrature_detent_decoder_accel.sv
// Self-checking testbench for the quadrature detent decoder: directed and random items vs. a predictor.
module tb_quadrature_detent_decoder_accel;
   import qdd_pkg::*;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   localparam logic [7:0]  DETENT_UP     = 8'hd4;
   localparam logic [7:0]  DETENT_DOWN   = 8'he8;
   localparam logic [15:0] TRANSITION_OK = 16'b0110_1001_1001_0110;
   localparam int          SPAN_MS       = 40;
   localparam int          BAND_MS       = 10;
   localparam int          COUNT_MAX     = 32767;
   localparam int          COUNT_MIN     = -32768;

   // inverted A/B codes, first step in the top bits
   localparam logic [7:0] CW_SEQ  = {2'b10, 2'b11, 2'b01, 2'b00};
   localparam logic [7:0] CCW_SEQ = {2'b01, 2'b11, 2'b10, 2'b00};

   localparam int IDLE_PCT    = 38;
   localparam int HOLD_CYCLES = 80;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 200;
   localparam int SAT_DETENTS = 48;

   class detent_scoreboard;
      rsp_item_type expected_q[$];
      logic [ACCEL_W-1:0] accel_mask;
      logic               report_on;
      logic [3:0]         trans_hist [NUM_ENCODERS];
      logic [7:0]         valid_hist [NUM_ENCODERS];
      logic [31:0]        last_ms    [NUM_ENCODERS];
      int                 acc        [NUM_ENCODERS];
      int                 errors;
      int                 checked;

      function void clear_encoder(int e);
         trans_hist[e] = '0;
         valid_hist[e] = '0;
         last_ms[e]    = '0;
         acc[e]        = 0;
      endfunction

      function new();
         accel_mask = '0;
         report_on  = 1'b1;
         errors     = 0;
         checked    = 0;
         for (int e = 0; e < NUM_ENCODERS; e++) clear_encoder(e);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_ACCEL_MASK) begin
            for (int e = 0; e < NUM_ENCODERS && e < ACCEL_W; e++)
               if (data[e] != accel_mask[e]) clear_encoder(e);
            accel_mask = data[ACCEL_W-1:0];
         end else begin
            report_on = data[0];
         end
      endfunction

      function void note_input(req_item_type it);
         rsp_item_type want;
         int           e;
         int           delta;
         int           sum;
         logic [3:0]   th;
         logic [7:0]   vh;
         logic [31:0]  dt;
         e     = int'(it.encoder_index);
         delta = 0;
         want  = '0;
         want.encoder_id = it.encoder_index;
         if (it.cmd == CMD_READ) begin
            want.count_value = 16'(acc[e]);
            acc[e] = 0;
         end else begin
            th = {trans_hist[e][1:0], ~it.pin_a_level, ~it.pin_b_level};
            trans_hist[e] = th;
            if (TRANSITION_OK[th]) begin
               vh = {valid_hist[e][3:0], th};
               valid_hist[e] = vh;
               if (vh == DETENT_UP) delta = 1;
               else if (vh == DETENT_DOWN) delta = -1;
            end
            if (delta != 0) begin
               if (accel_mask[e]) begin
                  dt = it.time_ms - last_ms[e];
                  if (dt < 32'(SPAN_MS))
                     delta = delta * int'((32'(SPAN_MS) - dt) / 32'(BAND_MS) + 1);
                  last_ms[e] = it.time_ms;
               end
               sum = acc[e] + delta;
               if (sum > COUNT_MAX) sum = COUNT_MAX;
               if (sum < COUNT_MIN) sum = COUNT_MIN;
               acc[e] = sum;
               want.detent_seen = 1'b1;
               want.step_delta  = 4'(delta);
               want.count_value = 16'(sum);
               if (report_on) acc[e] = 0;
            end else begin
               want.count_value = 16'(acc[e]);
            end
         end
         expected_q.push_back(want);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 100) $display("MISMATCH: %s", msg);
      endtask

      task check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("item with nothing expected: enc %0d count %0d",
                                      got.encoder_id, $signed(got.count_value)));
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.encoder_id !== want.encoder_id)
            report_mismatch($sformatf("item %0d encoder_id: got %0d, want %0d",
                                      checked, got.encoder_id, want.encoder_id));
         if (got.detent_seen !== want.detent_seen)
            report_mismatch($sformatf("item %0d detent_seen: got %0d, want %0d",
                                      checked, got.detent_seen, want.detent_seen));
         if (got.step_delta !== want.step_delta)
            report_mismatch($sformatf("item %0d step_delta: got %0d, want %0d",
                                      checked, $signed(got.step_delta), $signed(want.step_delta)));
         if (got.count_value !== want.count_value)
            report_mismatch($sformatf("item %0d count_value: got %0d, want %0d",
                                      checked, $signed(got.count_value),
                                      $signed(want.count_value)));
      endtask
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_item;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   detent_scoreboard sb;
   logic [31:0]      detent_clock [NUM_ENCODERS];
   bit               calm         = 1'b0;
   bit               hold_request = 1'b0;
   bit               holding      = 1'b0;
   int               items_sent   = 0;
   int               settings_used = 0;

   quadrature_detent_decoder_accel dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(logic cmd, logic [1:0] enc, logic a, logic b, logic [31:0] t);
      req_item_type it;
      it.cmd           = cmd;
      it.encoder_index = enc;
      it.pin_a_level   = a;
      it.pin_b_level   = b;
      it.time_ms       = t;
      while (!calm && !holding && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      sb.note_input(it);
      items_sent++;
   endtask

   task automatic send_code(logic [1:0] enc, logic [1:0] code, logic [31:0] t);
      send_item(CMD_SAMPLE, enc, ~code[1], ~code[0], t);
   endtask

   task automatic send_detent(logic [1:0] enc, bit ccw, logic [31:0] t);
      logic [7:0] seq;
      seq = ccw ? CCW_SEQ : CW_SEQ;
      for (int k = 0; k < 3; k++) send_code(enc, seq[7-2*k -: 2], $urandom());
      send_code(enc, seq[1:0], t);
   endtask

   task automatic random_step();
      logic [1:0]  enc;
      logic [7:0]  seq;
      logic [31:0] gap;
      int          r;
      int          n;
      enc = 2'($urandom_range(0, NUM_ENCODERS - 1));
      r   = $urandom_range(0, 99);
      if (r < 60) begin
         case ($urandom_range(0, 7))
            0:       gap = 32'd0;
            1:       gap = $urandom_range(1, 10);
            2:       gap = $urandom_range(11, 20);
            3:       gap = $urandom_range(21, 30);
            4:       gap = $urandom_range(31, 39);
            5:       gap = 32'd40;
            6:       gap = $urandom_range(41, 2000);
            default: gap = $urandom();
         endcase
         detent_clock[enc] = detent_clock[enc] + gap;
         send_detent(enc, 1'($urandom_range(0, 1)), detent_clock[enc]);
      end else if (r < 72) begin
         send_item(CMD_READ, enc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom());
      end else if (r < 86) begin
         send_item(CMD_SAMPLE, enc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom());
      end else begin
         // broken sequence: partial turn, then a random level
         seq = $urandom_range(0, 1) ? CCW_SEQ : CW_SEQ;
         n   = $urandom_range(1, 3);
         for (int k = 0; k < n; k++) send_code(enc, seq[7-2*k -: 2], $urandom());
         send_code(enc, 2'($urandom_range(0, 3)), $urandom());
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic apply_setting(logic [ACCEL_W-1:0] mask, logic report);
      drain();
      if ($urandom_range(0, 1)) begin
         write_csr(CSR_ACCEL_MASK, CSR_DATA_W'(mask));
         write_csr(CSR_REPORT, CSR_DATA_W'(report));
      end else begin
         write_csr(CSR_REPORT, CSR_DATA_W'(report));
         write_csr(CSR_ACCEL_MASK, CSR_DATA_W'(mask));
      end
      settings_used++;
   endtask

   initial begin
      int         phase_end;
      logic [1:0] sat_enc;
      sb = new();
      for (int e = 0; e < NUM_ENCODERS; e++) detent_clock[e] = $urandom();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults (fixed step, report each detent)
      send_item(CMD_READ, 2'd0, 1'b1, 1'b1, 32'hFFFF_FFFF);
      send_detent(2'd0, 1'b0, 32'h0000_0000);
      send_detent(2'd3, 1'b1, 32'hFFFF_FFFF);
      send_code(2'd2, 2'b11, 32'h0000_0000);
      send_code(2'd2, 2'b00, 32'hFFFF_FFFF);
      // directed: acceleration, accumulate, timestamp wrap
      apply_setting(4'hF, 1'b0);
      send_detent(2'd1, 1'b0, 32'hFFFF_FFFE);
      send_detent(2'd1, 1'b1, 32'd3);
      send_item(CMD_READ, 2'd1, 1'b0, 1'b0, 32'h0000_0000);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       apply_setting(4'h6, 1'b1);
            1:       apply_setting(4'h0, 1'b1);
            2:       apply_setting(4'h5, 1'b0);
            3:       apply_setting(4'hA, 1'b0);
            4:       apply_setting(4'h3, 1'b1);
            5:       apply_setting(4'hC, 1'b0);
            6:       apply_setting(4'($urandom()), 1'($urandom()));
            default: apply_setting(4'hF, 1'b1);
         endcase
         calm         = (p == 3);
         hold_request = (p == 1 || p == 5);
         phase_end    = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) random_step();
      end
      calm = 1'b0;

      // fast run both ways on one encoder, fastest acceleration, accumulating
      apply_setting(4'hF, 1'b0);
      sat_enc = 2'($urandom_range(0, NUM_ENCODERS - 1));
      send_item(CMD_READ, sat_enc, 1'b1, 1'b1, $urandom());
      for (int k = 0; k < SAT_DETENTS; k++) send_detent(sat_enc, 1'b0, detent_clock[sat_enc]);
      send_item(CMD_READ, sat_enc, 1'b0, 1'b1, $urandom());
      for (int k = 0; k < SAT_DETENTS; k++) send_detent(sat_enc, 1'b1, detent_clock[sat_enc]);
      send_item(CMD_READ, sat_enc, 1'b1, 1'b0, $urandom());

      drain();
      repeat (10) @(posedge clock);
      $display("Summary: %0d items sent, %0d results checked, %0d register settings applied.",
               items_sent, sb.checked, settings_used);
      $display("Covered reads, noise, broken turns, all gain bands, time wrap, long fast turns.");
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      int hold_left;
      hold_left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_item);
         if (hold_request && !holding) begin
            hold_request = 1'b0;
            holding      = 1'b1;
            hold_left    = HOLD_CYCLES;
         end
         if (holding) begin
            rsp_ready <= 1'b0;
            hold_left--;
            holding = (hold_left > 0);
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      wait (!reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: quadrature_detent_decoder_accel.f
sv/qdd_pkg.sv
sv/qdd_front.sv
sv/qdd_queue.sv
sv/qdd_back.sv
sv/quadrature_detent_decoder_accel.sv
dv/tb_quadrature_detent_decoder_accel.sv
